// ===== design/eutd_pkg.sv =====
// ----------------------------------------------------------------------------
// eutd_pkg
// Shared types, command codes and constants for the epoch seconds to UTC
// date converter: controller/datapath command and status, divisor tables.
// ----------------------------------------------------------------------------
package eutd_pkg;

  // datapath operation codes
  localparam logic [3:0] OP_NONE     = 4'd0;
  localparam logic [3:0] OP_LOAD     = 4'd1;
  localparam logic [3:0] OP_MUL      = 4'd2;
  localparam logic [3:0] OP_RES_SEC  = 4'd3;
  localparam logic [3:0] OP_RES_MIN  = 4'd4;
  localparam logic [3:0] OP_RES_QUAD = 4'd5;
  localparam logic [3:0] OP_YEAR     = 4'd6;
  localparam logic [3:0] OP_RES_HOUR = 4'd7;
  localparam logic [3:0] OP_RES_WDAY = 4'd8;
  localparam logic [3:0] OP_FEB      = 4'd9;
  localparam logic [3:0] OP_WALK     = 4'd10;

  // constant divisor select
  localparam logic [1:0] DIV_60   = 2'd0;
  localparam logic [1:0] DIV_QUAD = 2'd1;
  localparam logic [1:0] DIV_24   = 2'd2;
  localparam logic [1:0] DIV_7    = 2'd3;

  // calendar constants
  localparam logic [15:0] HOURS_PER_QUAD = 16'd35064;  // 1461 * 24
  localparam logic [13:0] HOURS_PER_YEAR = 14'd8760;   // 365 * 24
  localparam logic [13:0] HOURS_PER_LEAP = 14'd8784;   // 366 * 24
  localparam logic [10:0] DAYS_PER_QUAD  = 11'd1461;
  localparam logic [7:0]  FIRST_YEAR     = 8'd70;
  localparam logic [2:0]  EPOCH_WEEKDAY  = 3'd4;       // 1970-01-01 was a Thursday
  localparam logic [3:0]  LAST_MONTH     = 4'd11;
  localparam logic [8:0]  LEAP_DAY_MDAY  = 9'd60;      // february 29 as day count

  // controller to datapath
  typedef struct packed {
    logic [3:0] op;
    logic [1:0] div_sel;
    logic       out_load;
  } eutd_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic year_done;
    logic feb29;
    logic walk_done;
  } eutd_sts_t;

  // divisor value
  function automatic logic [15:0] div_value(input logic [1:0] sel);
    logic [15:0] d;
    case (sel)
      DIV_60:   d = 16'd60;
      DIV_QUAD: d = HOURS_PER_QUAD;
      DIV_24:   d = 16'd24;
      default:  d = 16'd7;
    endcase
    return d;
  endfunction

  // reciprocal, ceil(2^s / d), with s = 37, 35, 32, 32
  function automatic logic [31:0] div_recip(input logic [1:0] sel);
    logic [31:0] m;
    case (sel)
      DIV_60:   m = 32'd2290649225;
      DIV_QUAD: m = 32'd979915;
      DIV_24:   m = 32'd178956971;
      default:  m = 32'd613566757;
    endcase
    return m;
  endfunction

  // month length in a common year
  function automatic logic [4:0] month_len(input logic [3:0] mon);
    logic [4:0] len;
    case (mon)
      4'd1:                      len = 5'd28;
      4'd3, 4'd5, 4'd8, 4'd10:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

// ===== design/epoch_seconds_to_utc_date_core.sv =====
// ----------------------------------------------------------------------------
// epoch_seconds_to_utc_date_core
// Converts a signed count of seconds since 1970-01-01 00:00 UTC into the
// broken-down UTC calendar date and time.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_stall carries epoch_seconds; a transfer happens
//   when in_valid is high and in_stall is low. Negative counts read as zero.
//   Output channel out_valid/out_stall carries one result per input item.
//   One item is converted at a time: in_stall stays high from the transfer
//   until the result has been moved into the output register.
// Sequencing:
//   A new item is taken only once the previous result is in the output register.
//   The conversion time depends on the year stepper and the month walk
//   (one month per cycle); the five constant divides share one multiplier,
//   each as a multiply state and a result state.
// Stalls:
//   The output register holds a finished result while out_stall is high and
//   the block accepts and works on the next item meanwhile; it waits before
//   loading a second result until the first has been taken.
// Reset:
//   rst clears the sequencer to idle and drops out_valid.
// ----------------------------------------------------------------------------
module epoch_seconds_to_utc_date_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] epoch_seconds,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [5:0]         second,
  output logic [5:0]         minute,
  output logic [4:0]         hour,
  output logic [4:0]         day_of_month,
  output logic [3:0]         month,
  output logic [7:0]         year_since_1900,
  output logic [2:0]         weekday,
  output logic [8:0]         day_of_year
);
  import eutd_pkg::*;

  eutd_cmd_t cmd;
  eutd_sts_t sts;

  // sequencer
  eutd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // arithmetic and result registers
  eutd_dpath u_dpath (
    .clk             (clk),
    .cmd             (cmd),
    .epoch_seconds   (epoch_seconds),
    .sts             (sts),
    .second          (second),
    .minute          (minute),
    .hour            (hour),
    .day_of_month    (day_of_month),
    .month           (month),
    .year_since_1900 (year_since_1900),
    .weekday         (weekday),
    .day_of_year     (day_of_year)
  );

`ifndef NO_ASSERTIONS
  // an accepted item blocks the input until its result is loaded
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted while an item is in flight");

  // time of day fields stay in range
  a_time_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (second < 6'd60 && minute < 6'd60 && hour < 5'd24))
    else $error("time of day out of range");

  // month walk lands on a real date
  a_date_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (month <= 4'd11 && day_of_month != 5'd0 &&
                   day_of_year <= 9'd365 && weekday <= 3'd6))
    else $error("calendar date out of range");

  // reset leaves the block idle with no result pending
  a_reset_idle: assert property (@(posedge clk)
    rst |=> (!out_valid && !in_stall))
    else $error("block not idle after reset");
`endif

endmodule

// ===== design/eutd_dpath.sv =====
// ----------------------------------------------------------------------------
// eutd_dpath
// Datapath: working registers, one shared reciprocal multiplier for the
// constant divides, year stepper, month walker and result registers.
// ----------------------------------------------------------------------------
module eutd_dpath (
  input  logic                    clk,
  input  eutd_pkg::eutd_cmd_t     cmd,
  input  logic signed [31:0]      epoch_seconds,
  output eutd_pkg::eutd_sts_t     sts,
  output logic [5:0]              second,
  output logic [5:0]              minute,
  output logic [4:0]              hour,
  output logic [4:0]              day_of_month,
  output logic [3:0]              month,
  output logic [7:0]              year_since_1900,
  output logic [2:0]              weekday,
  output logic [8:0]              day_of_year
);
  import eutd_pkg::*;

  logic [30:0] acc;
  logic [62:0] prod;
  logic [25:0] quo;
  logic [30:0] rem;
  logic [5:0]  sec_w;
  logic [5:0]  min_w;
  logic [4:0]  hour_w;
  logic [8:0]  yday_w;
  logic [7:0]  year_w;
  logic [14:0] days_w;
  logic [8:0]  mday_w;
  logic [3:0]  mon_w;
  logic [2:0]  wday_w;
  logic        leap;
  logic [13:0] year_hours;
  logic [4:0]  cur_len;

  // quotient from the registered product, remainder by back-multiply
  always_comb begin
    case (cmd.div_sel)
      DIV_60:   quo = prod[62:37];
      DIV_QUAD: quo = prod[60:35];
      default:  quo = prod[57:32];
    endcase
    rem = acc - 31'(quo) * 31'(div_value(cmd.div_sel));
  end

  // year and month helpers
  assign leap       = (year_w[1:0] == 2'b00);
  assign year_hours = leap ? HOURS_PER_LEAP : HOURS_PER_YEAR;
  assign cur_len    = month_len(mon_w);

  assign sts.year_done = (acc < 31'(year_hours));
  assign sts.feb29     = leap && (mday_w == LEAP_DAY_MDAY);
  assign sts.walk_done = (mon_w == LAST_MONTH) || (9'(cur_len) >= mday_w);

  // working registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        acc <= epoch_seconds[31] ? 31'd0 : epoch_seconds[30:0];
      end
      OP_MUL: begin
        prod <= 63'(acc) * 63'(div_recip(cmd.div_sel));
      end
      OP_RES_SEC: begin
        sec_w <= rem[5:0];
        acc   <= 31'(quo);
      end
      OP_RES_MIN: begin
        min_w <= rem[5:0];
        acc   <= 31'(quo);
      end
      OP_RES_QUAD: begin
        year_w <= FIRST_YEAR + {1'b0, quo[4:0], 2'b00};
        days_w <= 15'(quo[4:0]) * 15'(DAYS_PER_QUAD);
        acc    <= rem;
      end
      OP_YEAR: begin
        acc    <= acc - 31'(year_hours);
        days_w <= days_w + (leap ? 15'd366 : 15'd365);
        year_w <= year_w + 8'd1;
      end
      OP_RES_HOUR: begin
        hour_w <= rem[4:0];
        yday_w <= quo[8:0];
        acc    <= 31'(days_w + 15'(quo[8:0]) + 15'(EPOCH_WEEKDAY));
        mday_w <= quo[8:0] + 9'd1;
        mon_w  <= 4'd0;
      end
      OP_RES_WDAY: begin
        wday_w <= rem[2:0];
      end
      OP_FEB: begin
        if (leap && mday_w == LEAP_DAY_MDAY) begin
          mon_w  <= 4'd1;
          mday_w <= 9'd29;
        end else if (leap && mday_w > LEAP_DAY_MDAY) begin
          mday_w <= mday_w - 9'd1;
        end
      end
      OP_WALK: begin
        mday_w <= mday_w - 9'(cur_len);
        mon_w  <= mon_w + 4'd1;
      end
      default: begin
      end
    endcase
  end

  // result registers
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      second          <= sec_w;
      minute          <= min_w;
      hour            <= hour_w;
      day_of_month    <= mday_w[4:0];
      month           <= mon_w;
      year_since_1900 <= year_w;
      weekday         <= wday_w;
      day_of_year     <= yday_w;
    end
  end

endmodule

// ===== design/eutd_ctrl.sv =====
// ----------------------------------------------------------------------------
// eutd_ctrl
// Controller: sequences the divides, year steps and month walk, and owns
// the input stall and output valid of the two channels.
// ----------------------------------------------------------------------------
module eutd_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  input  eutd_pkg::eutd_sts_t sts,
  output eutd_pkg::eutd_cmd_t cmd
);
  import eutd_pkg::*;

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_MUL_S  = 4'd1;
  localparam logic [3:0] ST_RES_S  = 4'd2;
  localparam logic [3:0] ST_MUL_M  = 4'd3;
  localparam logic [3:0] ST_RES_M  = 4'd4;
  localparam logic [3:0] ST_MUL_Q  = 4'd5;
  localparam logic [3:0] ST_RES_Q  = 4'd6;
  localparam logic [3:0] ST_YEAR   = 4'd7;
  localparam logic [3:0] ST_MUL_H  = 4'd8;
  localparam logic [3:0] ST_RES_H  = 4'd9;
  localparam logic [3:0] ST_MUL_W  = 4'd10;
  localparam logic [3:0] ST_RES_W  = 4'd11;
  localparam logic [3:0] ST_FEB    = 4'd12;
  localparam logic [3:0] ST_WALK   = 4'd13;
  localparam logic [3:0] ST_FINISH = 4'd14;

  logic [3:0] state;
  logic [3:0] state_next;

  // one item at a time
  assign in_stall = (state != ST_IDLE);

  // next state and datapath command
  always_comb begin
    state_next   = state;
    cmd.op       = OP_NONE;
    cmd.div_sel  = DIV_60;
    cmd.out_load = 1'b0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.op     = OP_LOAD;
          state_next = ST_MUL_S;
        end
      end
      ST_MUL_S: begin
        cmd.op     = OP_MUL;
        state_next = ST_RES_S;
      end
      ST_RES_S: begin
        cmd.op     = OP_RES_SEC;
        state_next = ST_MUL_M;
      end
      ST_MUL_M: begin
        cmd.op     = OP_MUL;
        state_next = ST_RES_M;
      end
      ST_RES_M: begin
        cmd.op     = OP_RES_MIN;
        state_next = ST_MUL_Q;
      end
      ST_MUL_Q: begin
        cmd.op      = OP_MUL;
        cmd.div_sel = DIV_QUAD;
        state_next  = ST_RES_Q;
      end
      ST_RES_Q: begin
        cmd.op      = OP_RES_QUAD;
        cmd.div_sel = DIV_QUAD;
        state_next  = ST_YEAR;
      end
      ST_YEAR: begin
        if (sts.year_done) begin
          state_next = ST_MUL_H;
        end else begin
          cmd.op = OP_YEAR;
        end
      end
      ST_MUL_H: begin
        cmd.op      = OP_MUL;
        cmd.div_sel = DIV_24;
        state_next  = ST_RES_H;
      end
      ST_RES_H: begin
        cmd.op      = OP_RES_HOUR;
        cmd.div_sel = DIV_24;
        state_next  = ST_MUL_W;
      end
      ST_MUL_W: begin
        cmd.op      = OP_MUL;
        cmd.div_sel = DIV_7;
        state_next  = ST_RES_W;
      end
      ST_RES_W: begin
        cmd.op      = OP_RES_WDAY;
        cmd.div_sel = DIV_7;
        state_next  = ST_FEB;
      end
      ST_FEB: begin
        cmd.op     = OP_FEB;
        state_next = sts.feb29 ? ST_FINISH : ST_WALK;
      end
      ST_WALK: begin
        if (sts.walk_done) begin
          state_next = ST_FINISH;
        end else begin
          cmd.op = OP_WALK;
        end
      end
      ST_FINISH: begin
        if (!out_valid || !out_stall) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // output valid: set on result load, cleared on transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

endmodule
